FILE: rtl/fre_pkg.sv
// ----------------------------------------------------------------------------
// fre_pkg
// Shared types and codes of the fragment reassembly engine.
// ----------------------------------------------------------------------------
package fre_pkg;

   localparam int OFF_W = 13;

   localparam logic [1:0] CMD_OPEN    = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic [1:0] STATUS_PLACED  = 2'd0;
   localparam logic [1:0] STATUS_HELD    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;
   localparam logic [1:0] STATUS_NO_SLOT = 2'd3;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] seq_number;
      logic [12:0] message_length;
      logic [31:0] frag_offset;
      logic [10:0] frag_length;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [63:0] arrival_time;
      logic [11:0] read_addr;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [1:0]  status;
      logic [12:0] progress;
      logic        complete;
      logic [63:0] deadline;
      logic [7:0]  read_byte;
   } rsp_type;

endpackage

FILE: rtl/fragment_reassembly_engine.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_engine
// Rebuilds one message from byte-streamed fragments, holding early ones.
// ----------------------------------------------------------------------------
// Payload bytes are taken one per cycle while the engine is idle. A byte with
// last_byte set leads to a posted report; an in-order fragment that ends first
// runs a drain: a scan per held fragment appended, a copy of its bytes from the
// held store to the message store (one read port each), and a closing scan.
// A read request passes through memory read, capture and post. No request is
// taken while a drain, read or report is in progress.
// The csr write port is always ready and sets the deadline timeout.
module fragment_reassembly_engine
   import fre_pkg::*;
#(
   parameter int MSG_BYTES  = 4096,
   parameter int HELD_SLOTS = 8,
   parameter int FRAG_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int MAW = $clog2(MSG_BYTES);
   localparam int HAW = $clog2(HELD_SLOTS * FRAG_BYTES);
   localparam int SW  = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
   localparam int PW  = $clog2(FRAG_BYTES + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_COPY = 5'b00100,
      ST_READ = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      MODE_NONE  = 4'b0001,
      MODE_PLACE = 4'b0010,
      MODE_HOLD  = 4'b0100,
      MODE_DROP  = 4'b1000
   } mode_type;

   logic [7:0] message_store [MSG_BYTES];
   logic [7:0] held_store [HELD_SLOTS * FRAG_BYTES];

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [10:0]      len_ff, len_in;
   logic [OFF_W-1:0] base_ff, base_in;
   logic [1:0]       status_ff, status_in;
   logic [OFF_W-1:0] expected_ff, expected_in;
   logic [OFF_W-1:0] total_ff, total_in;
   logic [31:0]      seq_ff, seq_in;
   logic [63:0]      deadline_ff, deadline_in;
   logic [31:0]      timeout_ff;
   logic             hv_ff [HELD_SLOTS];
   logic             hv_in [HELD_SLOTS];
   logic [OFF_W-1:0] hstart_ff [HELD_SLOTS];
   logic [OFF_W-1:0] hstart_in [HELD_SLOTS];
   logic [PW-1:0]    hsize_ff [HELD_SLOTS];
   logic [PW-1:0]    hsize_in [HELD_SLOTS];
   logic [HELD_SLOTS-1:0] older_ff [HELD_SLOTS];
   logic [HELD_SLOTS-1:0] older_in [HELD_SLOTS];
   logic [SW-1:0]    cp_slot_ff, cp_slot_in;
   logic [PW-1:0]    cp_i_ff, cp_i_in;
   logic [PW-1:0]    cp_size_ff, cp_size_in;
   logic [OFF_W-1:0] cp_dst_ff, cp_dst_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [MAW-1:0]   wr_addr_ff, wr_addr_in;
   logic             rd_ok_ff, rd_ok_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             msg_we, place_we, msg_re;
   logic [MAW-1:0]   msg_waddr, place_addr, msg_raddr;
   logic [7:0]       msg_wdata, msg_q;
   logic             held_we, held_re;
   logic [HAW-1:0]   held_waddr, held_raddr;
   logic [7:0]       held_q;

   logic             accept;
   logic             b_bad, any_free;
   logic [SW-1:0]    free_idx;
   logic [HELD_SLOTS-1:0] below, match;
   logic             pick_any;
   logic [SW-1:0]    pick_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !wr_pend_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // first-byte checks and free slot search
   always_comb begin
      b_bad = (req_payload.frag_length == 11'd0)
         || (32'(req_payload.frag_length) > FRAG_BYTES)
         || (req_payload.seq_number != seq_ff)
         || (req_payload.frag_offset < 32'(expected_ff))
         || ((33'(req_payload.frag_offset) + 33'(req_payload.frag_length))
             > 33'(total_ff));
      any_free = 1'b0;
      free_idx = '0;
      for (int s = HELD_SLOTS - 1; s >= 0; s--) begin
         if (!hv_ff[s]) begin
            any_free = 1'b1;
            free_idx = SW'(s);
         end
      end
   end

   // drain pick: oldest held fragment starting at the expected offset
   always_comb begin
      logic blocked;
      pick_any = 1'b0;
      pick_idx = '0;
      for (int s = 0; s < HELD_SLOTS; s++) begin
         below[s] = hv_ff[s] && (hstart_ff[s] < expected_ff);
         match[s] = hv_ff[s] && (hstart_ff[s] == expected_ff);
      end
      for (int s = 0; s < HELD_SLOTS; s++) begin
         blocked = 1'b0;
         for (int j = 0; j < HELD_SLOTS; j++) begin
            if (j != s && match[j] && older_ff[j][s]) begin
               blocked = 1'b1;
            end
         end
         if (match[s] && !blocked) begin
            pick_any = 1'b1;
            pick_idx = SW'(s);
         end
      end
   end

   always_comb begin
      mode_type  m;
      logic [PW-1:0] pos;
      logic [10:0] len;
      logic [OFF_W-1:0] base;
      logic [SW-1:0] slot;
      logic [1:0] st;
      logic [63:0] dl;
      logic [OFF_W-1:0] exp_new;

      state_in    = state_ff;
      mode_in     = mode_ff;
      slot_in     = slot_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      base_in     = base_ff;
      status_in   = status_ff;
      expected_in = expected_ff;
      total_in    = total_ff;
      seq_in      = seq_ff;
      deadline_in = deadline_ff;
      hv_in       = hv_ff;
      hstart_in   = hstart_ff;
      hsize_in    = hsize_ff;
      older_in    = older_ff;
      cp_slot_in  = cp_slot_ff;
      cp_i_in     = cp_i_ff;
      cp_size_in  = cp_size_ff;
      cp_dst_in   = cp_dst_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      rd_ok_in    = rd_ok_ff;
      res_in      = res_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      place_we   = 1'b0;
      place_addr = '0;
      held_we    = 1'b0;
      held_waddr = '0;
      held_re    = 1'b0;
      held_raddr = '0;
      msg_re     = 1'b0;
      msg_raddr  = '0;

      m    = mode_ff;
      pos  = pos_ff;
      len  = len_ff;
      base = base_ff;
      slot = slot_ff;
      st   = status_ff;
      dl   = deadline_ff;
      exp_new = expected_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.cmd)
                  CMD_OPEN: begin
                     seq_in = req_payload.seq_number;
                     total_in = (32'(req_payload.message_length) > MSG_BYTES)
                        ? OFF_W'(MSG_BYTES) : OFF_W'(req_payload.message_length);
                     expected_in = '0;
                     deadline_in = '0;
                     for (int s = 0; s < HELD_SLOTS; s++) hv_in[s] = 1'b0;
                     mode_in = MODE_NONE;
                     pos_in  = '0;
                  end
                  CMD_PAYLOAD: begin
                     if (mode_ff == MODE_NONE) begin
                        pos  = '0;
                        len  = req_payload.frag_length;
                        base = OFF_W'(req_payload.frag_offset);
                        if (b_bad) begin
                           m  = MODE_DROP;
                           st = STATUS_INVALID;
                        end else if (req_payload.frag_offset == 32'(expected_ff)) begin
                           m  = MODE_PLACE;
                           st = STATUS_PLACED;
                           dl = req_payload.arrival_time + 64'(timeout_ff);
                        end else if (any_free) begin
                           m    = MODE_HOLD;
                           slot = free_idx;
                           st   = STATUS_HELD;
                        end else begin
                           m  = MODE_DROP;
                           st = STATUS_NO_SLOT;
                        end
                     end
                     if ((32'(pos) < 32'(len)) && (m == MODE_PLACE || m == MODE_HOLD)) begin
                        if (m == MODE_PLACE) begin
                           place_we   = 1'b1;
                           place_addr = MAW'(base + OFF_W'(pos));
                        end else begin
                           held_we    = 1'b1;
                           held_waddr = HAW'(32'(slot) * FRAG_BYTES) + HAW'(pos);
                        end
                        pos = pos + PW'(1);
                     end
                     deadline_in = dl;
                     status_in   = st;
                     len_in      = len;
                     base_in     = base;
                     slot_in     = slot;
                     pos_in      = pos;
                     mode_in     = m;
                     if (req_payload.last_byte) begin
                        mode_in = MODE_NONE;
                        if (m == MODE_PLACE) begin
                           expected_in = base + OFF_W'(pos);
                           state_in = ST_SCAN;
                        end else begin
                           if (m == MODE_HOLD) begin
                              hv_in[slot]     = 1'b1;
                              hstart_in[slot] = base;
                              hsize_in[slot]  = pos;
                              for (int j = 0; j < HELD_SLOTS; j++) begin
                                 older_in[j][slot] = 1'b1;
                              end
                              older_in[slot] = '0;
                           end
                           res_in             = '0;
                           res_in.result_kind = KIND_REPORT;
                           res_in.status      = st;
                           res_in.progress    = expected_ff;
                           res_in.complete    = expected_ff >= total_ff;
                           res_in.deadline    = dl;
                           state_in = ST_EMIT;
                        end
                     end
                  end
                  CMD_READ: begin
                     msg_re    = 1'b1;
                     msg_raddr = MAW'(req_payload.read_addr);
                     rd_ok_in  = 32'(req_payload.read_addr) < MSG_BYTES;
                     state_in  = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            for (int s = 0; s < HELD_SLOTS; s++) begin
               if (below[s]) hv_in[s] = 1'b0;
            end
            if (pick_any) begin
               hv_in[pick_idx] = 1'b0;
               exp_new     = expected_ff + OFF_W'(hsize_ff[pick_idx]);
               expected_in = exp_new;
               cp_slot_in  = pick_idx;
               cp_i_in     = '0;
               cp_size_in  = hsize_ff[pick_idx];
               cp_dst_in   = hstart_ff[pick_idx];
               state_in    = ST_COPY;
            end else begin
               res_in             = '0;
               res_in.result_kind = KIND_REPORT;
               res_in.status      = STATUS_PLACED;
               res_in.progress    = expected_ff;
               res_in.complete    = expected_ff >= total_ff;
               res_in.deadline    = deadline_ff;
               state_in = ST_EMIT;
            end
         end
         ST_COPY: begin
            held_re    = 1'b1;
            held_raddr = HAW'(32'(cp_slot_ff) * FRAG_BYTES) + HAW'(cp_i_ff);
            wr_pend_in = 1'b1;
            wr_addr_in = MAW'(cp_dst_ff + OFF_W'(cp_i_ff));
            cp_i_in    = cp_i_ff + PW'(1);
            if ((32'(cp_i_ff) + 32'd1) >= 32'(cp_size_ff)) begin
               state_in = ST_SCAN;
            end
         end
         ST_READ: begin
            res_in             = '0;
            res_in.result_kind = KIND_READ;
            res_in.read_byte   = rd_ok_ff ? msg_q : 8'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // message store write: drain copy or in-order payload byte
   always_comb begin
      msg_we    = wr_pend_ff || place_we;
      msg_waddr = wr_pend_ff ? wr_addr_ff : place_addr;
      msg_wdata = wr_pend_ff ? held_q : req_payload.data_byte;
   end

   always_ff @(posedge clock) begin
      if (msg_we) begin
         message_store[msg_waddr] <= msg_wdata;
      end
      if (msg_re) begin
         msg_q <= message_store[msg_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_store[held_waddr] <= req_payload.data_byte;
      end
      if (held_re) begin
         held_q <= held_store[held_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_NONE;
         pos_ff       <= '0;
         expected_ff  <= '0;
         total_ff     <= '0;
         seq_ff       <= '0;
         deadline_ff  <= '0;
         timeout_ff   <= 32'd1000;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < HELD_SLOTS; s++) hv_ff[s] <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         expected_ff  <= expected_in;
         total_ff     <= total_in;
         seq_ff       <= seq_in;
         deadline_ff  <= deadline_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         hv_ff        <= hv_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      len_ff     <= len_in;
      base_ff    <= base_in;
      status_ff  <= status_in;
      hstart_ff  <= hstart_in;
      hsize_ff   <= hsize_in;
      older_ff   <= older_in;
      cp_slot_ff <= cp_slot_in;
      cp_i_ff    <= cp_i_in;
      cp_size_ff <= cp_size_in;
      cp_dst_ff  <= cp_dst_in;
      wr_addr_ff <= wr_addr_in;
      rd_ok_ff   <= rd_ok_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

endmodule
